FILE: sv/swa_pkg.sv
`timescale 1ns / 1ps

package swa_pkg;

  localparam int SAMPLE_W = 32;
  localparam int AGG_W    = 38;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam longint AGG_MAX = 64'sd137438953471;

  localparam logic [1:0] MODE_AVG = 2'd0;
  localparam logic [1:0] MODE_SUM = 2'd1;
  localparam logic [1:0] MODE_MAX = 2'd2;
  localparam logic [1:0] MODE_MIN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_AGG,
    S_DIV,
    S_STORE,
    S_DONE
  } swa_state_t;

  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic walk_issue;
    logic agg_take;
    logic div_start;
    logic quot_take;
    logic store;
    logic out_load;
  } swa_cmd_t;

  typedef struct packed {
    logic warm;
    logic walk_last;
    logic mode_avg;
    logic div_done;
  } swa_status_t;

endpackage

FILE: sv/sliding_window_aggregate_top.sv
`timescale 1ns / 1ps

// Sliding-window aggregate. Each request carries one signed 32-bit sample and
// yields one result: the average (truncated toward zero), sum, maximum or
// minimum of the previous window_len samples, never the current one. While
// the window loads (the first window_len requests after reset or after any
// write of window_len) the result is the previous sample instead, 0 for the
// very first, and warming_up is set. A window_len of 0 acts as 1, above
// WINDOW_MAX it acts as WINDOW_MAX. The sum saturates to the 38-bit result
// range. One request is in work at a time; a finished result waits in the
// output register, so the next request is taken while it is still stalled.
// During warm-up a request skips the walk. For sum, maximum and minimum each
// request walks over the L stored samples through the single read port of the
// ring store; the average adds the shared restoring divider, one bit a cycle
// over SW = 32 + clog2(WINDOW_MAX + 1) bits (39 at the default).
// Configuration writes are taken only while no request is in work, and only
// when no result is pending; agg_mode takes effect on the next result. A
// request offered in the cycle of a register write is held; the write goes first.
module sliding_window_aggregate_top #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swa_pkg::AGG_W-1:0]    agg_value,
  output logic                                warming_up,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swa_pkg::CFG_W-1:0]           cfg_data
);

  import swa_pkg::*;

  swa_cmd_t    cmd;
  swa_status_t st;

  // sequence each request: walk, aggregate or divide, store, deliver
  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .st        (st)
  );

  // ring store, accumulators, divider and result registers
  swa_dp #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (sample_value),
    .agg_value    (agg_value),
    .warming_up   (warming_up)
  );

endmodule

FILE: sv/swa_div.sv
`timescale 1ns / 1ps

module swa_div #(
  parameter int SW = 39,
  parameter int LW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] dividend,
  input  logic [LW-1:0]        divisor,
  output logic                 done,
  output logic signed [SW-1:0] quotient
);

  localparam int CW = $clog2(SW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [LW-1:0] rem;
  logic [LW-1:0] dvs;
  logic [SW-1:0] quo;
  logic          neg;

  logic [LW:0]   rem_sh;
  logic [LW:0]   rem_diff;
  logic          fit;

  // one restoring step per cycle on the magnitude
  always_comb begin
    rem_sh   = {rem, quo[SW-1]};
    fit      = rem_sh >= {1'b0, dvs};
    rem_diff = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
      neg <= dividend[SW-1];
      rem <= '0;
      dvs <= divisor;
      cnt <= CW'(SW);
    end else if (busy) begin
      rem <= fit ? rem_diff[LW-1:0] : rem_sh[LW-1:0];
      quo <= {quo[SW-2:0], fit};
      cnt <= cnt - CW'(1);
    end
  end

  // truncate toward zero: negate the magnitude quotient for a negative sum
  assign quotient = neg ? -signed'(quo) : signed'(quo);

endmodule

FILE: sv/swa_dp.sv
`timescale 1ns / 1ps

module swa_dp #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  swa_pkg::swa_cmd_t                  cmd,
  output swa_pkg::swa_status_t               st,
  input  logic [swa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swa_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample_value,
  output logic signed [swa_pkg::AGG_W-1:0]   agg_value,
  output logic                               warming_up
);

  import swa_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int SW = SAMPLE_W + LW;
  localparam int WW = (SW > AGG_W) ? SW : AGG_W;
  localparam logic signed [WW-1:0] SAT_HI = WW'(AGG_MAX);
  localparam logic signed [WW-1:0] SAT_LO = WW'(-AGG_MAX - 64'sd1);

  logic [1:0]                 agg_mode;
  logic [CFG_W-1:0]           window_len;
  logic [LW-1:0]              fill_count;
  logic [AW-1:0]              oldest_index;
  logic signed [SAMPLE_W-1:0] prior_sample;
  logic signed [SAMPLE_W-1:0] sample_hold;
  logic                       is_warm;
  logic [LW-1:0]              walk_idx;
  logic                       rd_valid;
  logic                       rd_first;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SW-1:0]       sum;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [AGG_W-1:0]    res;
  logic                       res_warm;

  logic signed [SAMPLE_W-1:0] ring_store [WINDOW_MAX];

  logic [LW-1:0]              n_eff;
  logic [AW-1:0]              oi_use;
  logic [LW-1:0]              oi_inc;
  logic [AW-1:0]              wr_addr;
  logic signed [WW-1:0]       sum_w;
  logic signed [WW-1:0]       sum_sat;
  logic signed [AGG_W-1:0]    agg_res;
  logic signed [SW-1:0]       quot;
  logic signed [WW-1:0]       quot_w;
  logic                       div_done;

  // effective window length: zero acts as one, clamp to the store depth
  always_comb begin
    if (window_len == '0) begin
      n_eff = LW'(1);
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      n_eff = LW'(WINDOW_MAX);
    end else begin
      n_eff = LW'(window_len);
    end
  end

  always_comb begin
    oi_use  = (LW'(oldest_index) >= n_eff) ? '0 : oldest_index;
    oi_inc  = LW'(oi_use) + LW'(1);
    wr_addr = is_warm ? fill_count[AW-1:0] : oi_use;
  end

  always_comb begin
    sum_w = WW'(sum);
    if (sum_w > SAT_HI) begin
      sum_sat = SAT_HI;
    end else if (sum_w < SAT_LO) begin
      sum_sat = SAT_LO;
    end else begin
      sum_sat = sum_w;
    end
    unique case (agg_mode)
      MODE_SUM: agg_res = sum_sat[AGG_W-1:0];
      MODE_MAX: agg_res = AGG_W'(hi);
      MODE_MIN: agg_res = AGG_W'(lo);
      MODE_AVG: agg_res = sum_sat[AGG_W-1:0];
    endcase
    quot_w = WW'(quot);
  end

  always_comb begin
    st.warm      = fill_count < n_eff;
    st.walk_last = walk_idx == (n_eff - LW'(1));
    st.mode_avg  = agg_mode == MODE_AVG;
    st.div_done  = div_done;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      agg_mode     <= MODE_AVG;
      window_len   <= WINDOW_LEN_RESET;
      fill_count   <= '0;
      oldest_index <= '0;
      prior_sample <= '0;
      rd_valid     <= 1'b0;
      rd_first     <= 1'b0;
    end else begin
      rd_valid <= cmd.walk_issue;
      rd_first <= cmd.walk_issue && walk_idx == '0;
      if (cmd.cfg_write) begin
        unique case (cfg_index)
          REG_AGG_MODE: agg_mode <= cfg_data[1:0];
          REG_WINDOW_LEN: begin
            window_len   <= cfg_data;
            fill_count   <= '0;
            oldest_index <= '0;
          end
        endcase
      end
      if (cmd.store) begin
        prior_sample <= sample_hold;
        if (is_warm) begin
          fill_count <= fill_count + LW'(1);
        end else begin
          oldest_index <= (oi_inc >= n_eff) ? '0 : oi_inc[AW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_hold <= sample_value;
      is_warm     <= st.warm;
      walk_idx    <= '0;
    end else if (cmd.walk_issue) begin
      walk_idx <= walk_idx + LW'(1);
    end
    if (rd_valid) begin
      if (rd_first) begin
        sum <= SW'(rd_data);
        hi  <= rd_data;
        lo  <= rd_data;
      end else begin
        sum <= sum + SW'(rd_data);
        if (rd_data > hi) begin
          hi <= rd_data;
        end
        if (rd_data < lo) begin
          lo <= rd_data;
        end
      end
    end
    if (cmd.agg_take) begin
      res <= agg_res;
    end else if (cmd.quot_take) begin
      res <= quot_w[AGG_W-1:0];
    end else if (cmd.store && is_warm) begin
      res <= AGG_W'(prior_sample);
    end
    if (cmd.store) begin
      res_warm <= is_warm;
    end
    if (cmd.out_load) begin
      agg_value  <= res;
      warming_up <= res_warm;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring_store[wr_addr] <= sample_hold;
    end
    rd_data <= ring_store[walk_idx[AW-1:0]];
  end

  swa_div #(
    .SW(SW),
    .LW(LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (quot)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= n_eff)
    else $error("fill count beyond window length");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_count == n_eff) |-> (LW'(oldest_index) < n_eff))
    else $error("oldest index outside full window");
`endif

endmodule

FILE: sv/swa_ctrl.sv
`timescale 1ns / 1ps

module swa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  output swa_pkg::swa_cmd_t    cmd,
  input  swa_pkg::swa_status_t st
);

  import swa_pkg::*;

  swa_state_t state;
  swa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cfg_ready     = (state == S_IDLE) && !out_valid;
    cmd.cfg_write = cfg_valid && cfg_ready;
    // a register write goes first; hold a request offered in the same cycle
    in_stall      = (state != S_IDLE) || cmd.cfg_write;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_next = st.warm ? S_STORE : S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        if (st.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_AGG;
      end
      S_AGG: begin
        if (st.mode_avg) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.agg_take = 1'b1;
          state_next   = S_STORE;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.quot_take = 1'b1;
          state_next    = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule

FILE: bench/sliding_window_aggregate_top_tb.sv
`timescale 1ns / 1ps

module sliding_window_aggregate_top_tb;
  import swa_pkg::*;

  localparam int WIN_MAX      = 64;
  localparam int ITEMS        = 1000;
  localparam int LONG_HOLD    = 300;      // receiver hold-off that backs the block up
  localparam int SETTLE_WAIT  = 4;        // quiet cycles before a register write
  localparam int TAIL_WAIT    = 120;      // lets the longest request finish
  localparam int CYCLE_LIMIT  = 1500000;

  // How the samples of one window set are drawn.
  typedef enum int {MIX_RANDOM, MIX_SMALL, MIX_EDGE, MIX_FIXED} sample_mix_t;

  typedef struct {
    logic signed [AGG_W-1:0] agg;
    logic                    warm;
  } agg_result_t;

  // Tracks the window contents and holds the results still owed by the block.
  class window_scoreboard;
    logic signed [SAMPLE_W-1:0] ring [WIN_MAX];
    int                         oldest;
    int                         filled;
    logic signed [SAMPLE_W-1:0] prior;
    logic [1:0]                 mode;
    logic [CFG_W-1:0]           wlen;
    agg_result_t                owed[$];
    int                         errors;

    function new();
      oldest = 0;
      filled = 0;
      prior  = '0;
      mode   = MODE_AVG;
      wlen   = WINDOW_LEN_RESET;
      errors = 0;
    endfunction

    function int window_size();
      if (wlen == 0) return 1;
      if (wlen > WIN_MAX) return WIN_MAX;
      return wlen;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_AGG_MODE) begin
        mode = val[1:0];
      end else begin
        // any window write restarts the load, prior sample survives
        wlen   = val;
        filled = 0;
        oldest = 0;
      end
    endfunction

    function logic signed [AGG_W-1:0] window_aggregate(int n);
      longint                     total;
      logic signed [SAMPLE_W-1:0] hi;
      logic signed [SAMPLE_W-1:0] lo;
      total = 0;
      hi = ring[0];
      lo = ring[0];
      for (int k = 0; k < n; k++) begin
        total += ring[k];
        if (ring[k] > hi) hi = ring[k];
        if (ring[k] < lo) lo = ring[k];
      end
      case (mode)
        MODE_AVG: return total / n;
        MODE_SUM: begin
          if (total > AGG_MAX) return AGG_MAX;
          if (total < -AGG_MAX - 1) return -AGG_MAX - 1;
          return total;
        end
        MODE_MAX: return hi;
        default:  return lo;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      agg_result_t r;
      int          n;
      n = window_size();
      if (filled < n) begin
        ring[filled % WIN_MAX] = s;
        filled++;
        r.agg  = prior;
        r.warm = 1'b1;
      end else begin
        r.agg = window_aggregate(n);
        if (oldest >= n) oldest = 0;
        ring[oldest] = s;
        oldest++;
        if (oldest >= n) oldest = 0;
        r.warm = 1'b0;
      end
      prior = s;
      owed.push_back(r);
    endfunction

    function void check_result(logic signed [AGG_W-1:0] agg, logic warm);
      agg_result_t r;
      if (owed.size() == 0) begin
        $error("unexpected result: agg_value %0d warming_up %0b", agg, warm);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (agg !== r.agg) begin
        $error("agg_value: expected %0d, got %0d", r.agg, agg);
        errors++;
      end
      if (warm !== r.warm) begin
        $error("warming_up: expected %0b, got %0b", r.warm, warm);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_W-1:0]    sample_value;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [AGG_W-1:0]       agg_value;
  logic                          warming_up;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_data;

  window_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  int hold_requests;   // bump to ask the receiver for one long hold-off
  int cycle_count;

  sliding_window_aggregate_top #(
    .WINDOW_MAX(WIN_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_value(sample_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .agg_value(agg_value),
    .warming_up(warming_up),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Offer one sample, idling first at the current rate; return at the
  // edge that takes the request and log it with the scoreboard.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Drop the input and wait until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Write one register while the block is quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.apply_write(idx, val);
  endtask

  // Mode writes carry random upper bits; only the low two count.
  task automatic write_mode(input logic [1:0] m);
    write_reg(REG_AGG_MODE, {5'($urandom()), m});
  endtask

  // Mostly short windows, a few full-size ones and the out-of-range codes.
  function automatic logic [CFG_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 7'd64;
    if (r < 7)  return 7'd127;
    if (r < 9)  return 7'($urandom_range(65, 126));
    if (r < 13) return 7'd0;
    if (r < 25) return 7'($urandom_range(9, 32));
    return 7'($urandom_range(1, 8));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_mix_t mix,
                                                             logic signed [SAMPLE_W-1:0] fixed);
    int v;
    case (mix)
      MIX_FIXED: return fixed;
      MIX_SMALL: begin
        // tight range: ties in max/min and negative sums that truncate
        v = $urandom_range(0, 16);
        return v - 8;
      end
      MIX_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return -1;
          default: return $urandom();
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Receiver: check accepted results, then pick next cycle's stall.
  // A long hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        sb.check_result(agg_value, warming_up);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // Watchdog: give up on a hang.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int                         sent;
    int                         seg;
    int                         eff;
    int                         count;
    bit                         pressure_done;
    bit                         pressing;
    logic [CFG_W-1:0]           wl;
    logic [1:0]                 m;
    sample_mix_t                mix;
    logic signed [SAMPLE_W-1:0] fixed;

    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    sample_value  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_idle_pct   = 14;
    out_idle_pct  = 46;
    hold_requests = 0;
    sent          = 0;
    seg           = 0;
    pressure_done = 0;
    pressing      = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings (average over 4). Load with the sample
    // extremes, then average a window whose sum is -1 (truncates to 0)
    // and one that holds the most negative sample.
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(-1);
    send_sample(1);
    send_sample(0);
    send_sample(5);

    // Mode changes land on the next result without restarting the load.
    write_mode(MODE_SUM);
    send_sample(3);
    write_mode(MODE_MAX);
    send_sample(-7);
    write_mode(MODE_MIN);
    send_sample(2);

    // Window length 0 behaves as a single-entry window.
    write_reg(REG_WINDOW_LEN, 7'd0);
    send_sample(-5);
    send_sample(6);
    send_sample(7);

    // Two-entry average of a negative odd sum rounds toward zero.
    write_reg(REG_WINDOW_LEN, 7'd2);
    write_mode(MODE_AVG);
    send_sample(-3);
    send_sample(0);
    send_sample(5);
    send_sample(-4);

    // Rewriting the same length still restarts the load.
    write_reg(REG_WINDOW_LEN, 7'd1);
    write_mode(MODE_SUM);
    send_sample(9);
    write_reg(REG_WINDOW_LEN, 7'd1);
    send_sample(10);
    send_sample(11);

    // Random window sets. The first two are pinned to the largest window
    // filled with one extreme, so the sum and average reach their limits.
    while (sent < ITEMS) begin
      if (sent < ITEMS / 3) begin
        in_idle_pct  = 14;
        out_idle_pct = 46;
      end else if (sent < 2 * ITEMS / 3) begin
        in_idle_pct  = 46;
        out_idle_pct = 14;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      if (seg == 0) begin
        wl    = 7'd64;
        m     = MODE_SUM;
        mix   = MIX_FIXED;
        fixed = 32'sh8000_0000;
      end else if (seg == 1) begin
        wl    = 7'd127;
        m     = MODE_AVG;
        mix   = MIX_FIXED;
        fixed = 32'sh7FFF_FFFF;
      end else begin
        wl    = pick_window();
        m     = 2'($urandom_range(0, 3));
        mix   = sample_mix_t'($urandom_range(0, 3));
        fixed = $urandom();
      end

      write_reg(REG_WINDOW_LEN, wl);
      write_mode(m);

      // once, with no idling, hold the receiver off long enough to back
      // the block up into its input
      pressing = 0;
      if (!pressure_done && sent >= 2 * ITEMS / 3) begin
        hold_requests++;
        pressure_done = 1;
        pressing      = 1;
      end

      eff   = (wl == 0) ? 1 : ((wl > WIN_MAX) ? WIN_MAX : wl);
      count = eff + $urandom_range(4, 30);
      // now and then cut a set off before its window has loaded
      if (seg > 1 && !pressing && $urandom_range(0, 9) == 0)
        count = $urandom_range(0, eff);

      for (int k = 0; k < count; k++) begin
        if (!pressing && k == count / 2 && $urandom_range(0, 3) == 0)
          write_mode(2'($urandom_range(0, 3)));
        send_sample(pick_sample(mix, fixed));
        sent++;
      end
      seg++;
    end

    // Drain, then give the block time to show any extra result.
    settle();
    repeat (TAIL_WAIT) @(posedge clk);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
